FILE: hdl/hdlczbs_pkg.sv
// ----------------------------------------------------------------------------
// HDLC zero-bit stuffer package
// Payload types and fixed widths shared by the stuffer and its checker.
// ----------------------------------------------------------------------------
package hdlczbs_pkg;

  // Leftover bits kept between bytes of a message (never a whole byte).
  localparam int unsigned PEND_W     = 7;
  localparam int unsigned PEND_CNT_W = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned VBITS_W    = 4;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_message;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic [VBITS_W-1:0] valid_bits;
    logic               last_out;
  } out_t;

endpackage

FILE: hdl/hdlc_zero_bit_stuffer.sv
// ----------------------------------------------------------------------------
// HDLC zero-bit stuffer
// Inserts a zero after every run of ONES_LIMIT ones and repacks the stream
// into bytes, MSB first, flushing a zero-padded partial byte at message end.
// ----------------------------------------------------------------------------
// An input byte is held in an input register, stuffed and packed by one
// pass of combinational logic, and its results (one to three bytes) are
// loaded together into a small result buffer that presents one result per
// cycle while the output is not stalled. The buffer port sets the rate, so
// the block sustains one input byte per cycle when every byte yields one
// result and the output is not stalled. A new input byte is accepted while
// earlier results are still being delivered.
module hdlc_zero_bit_stuffer #(
  parameter int unsigned ONES_LIMIT = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hdlczbs_pkg::in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hdlczbs_pkg::out_t  out_data_o
);

  localparam int unsigned RUN_W     = $clog2(ONES_LIMIT + 1);
  localparam int unsigned MAX_STUFF = (ONES_LIMIT - 1 + hdlczbs_pkg::BYTE_W) / ONES_LIMIT;
  localparam int unsigned TOT       = hdlczbs_pkg::PEND_W + hdlczbs_pkg::BYTE_W + MAX_STUFF;
  localparam int unsigned CNT_W     = $clog2(TOT + 1);
  localparam int unsigned NFULL     = TOT / hdlczbs_pkg::BYTE_W;
  localparam int unsigned NRES      = NFULL + 1;
  localparam int unsigned FULL_W    = CNT_W - 3;
  localparam int unsigned BCNT_W    = $clog2(NRES + 1);

  // Input register.
  hdlczbs_pkg::in_t in_q;
  logic             in_vld_q;

  // Stream state carried between bytes.
  logic [hdlczbs_pkg::PEND_W-1:0]     pend_q, pend_d;
  logic [hdlczbs_pkg::PEND_CNT_W-1:0] pcnt_q, pcnt_d;
  logic [RUN_W-1:0]                   run_q, run_d;

  // Result buffer; entry 0 is the one on the output.
  hdlczbs_pkg::out_t buf_q [NRES];
  logic [BCNT_W-1:0] bcnt_q;

  logic              load;
  logic              pop;
  logic [TOT-1:0]    acc;
  logic [CNT_W-1:0]  cnt;
  logic [RUN_W-1:0]  run;
  logic [FULL_W-1:0] full;
  logic [2:0]        rem;
  logic [7:0]        part;
  logic [TOT-1:0]    shifted [NFULL];
  hdlczbs_pkg::out_t res [NRES];
  logic [BCNT_W-1:0] nres;

  // Stuff the byte onto the pending bits, one input bit per step.
  always_comb begin
    acc = TOT'(pend_q);
    cnt = CNT_W'(pcnt_q);
    run = run_q;
    for (int j = 7; j >= 0; j--) begin
      acc = {acc[TOT-2:0], in_q.data_byte[j]};
      cnt = cnt + CNT_W'(1);
      if (in_q.data_byte[j]) begin
        if (run == RUN_W'(ONES_LIMIT - 1)) begin
          acc = {acc[TOT-2:0], 1'b0};
          cnt = cnt + CNT_W'(1);
          run = '0;
        end else begin
          run = run + RUN_W'(1);
        end
      end else begin
        run = '0;
      end
    end
  end

  assign full = cnt[CNT_W-1:3];
  assign rem  = cnt[2:0];
  assign part = acc[7:0] << (4'd8 - {1'b0, rem});

  // Split the packed stream into result bytes, oldest first.
  always_comb begin
    for (int k = 0; k < NFULL; k++) begin
      shifted[k] = acc >> (cnt - CNT_W'(8 * (k + 1)));
    end
    // The entry right after the full bytes carries the flushed partial byte.
    for (int k = 0; k < NRES; k++) begin
      res[k].out_byte   = part;
      res[k].valid_bits = {1'b0, rem};
      res[k].last_out   = 1'b1;
    end
    for (int k = 0; k < NFULL; k++) begin
      if (FULL_W'(k) < full) begin
        res[k].out_byte   = shifted[k][7:0];
        res[k].valid_bits = 4'd8;
        res[k].last_out   = in_q.end_of_message && (rem == 3'd0) &&
                            (FULL_W'(k + 1) == full);
      end
    end
    nres = BCNT_W'(full) + BCNT_W'(in_q.end_of_message && (rem != 3'd0));
  end

  always_comb begin
    if (in_q.end_of_message) begin
      pend_d = '0;
      pcnt_d = '0;
      run_d  = '0;
    end else begin
      pend_d = acc[6:0] & ~(7'h7F << rem);
      pcnt_d = rem;
      run_d  = run;
    end
  end

  assign out_valid_o = (bcnt_q != '0);
  assign out_data_o  = buf_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  // A stuffed byte moves into the buffer once the last held result leaves.
  assign load        = in_vld_q && ((bcnt_q == '0) || (bcnt_q == BCNT_W'(1) && !out_stall_i));
  assign in_stall_o  = in_vld_q && !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      bcnt_q   <= '0;
      pend_q   <= '0;
      pcnt_q   <= '0;
      run_q    <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_vld_q <= 1'b1;
      end else if (load) begin
        in_vld_q <= 1'b0;
      end
      if (load) begin
        bcnt_q <= nres;
        pend_q <= pend_d;
        pcnt_q <= pcnt_d;
        run_q  <= run_d;
      end else if (pop) begin
        bcnt_q <= bcnt_q - BCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (load) begin
      for (int k = 0; k < NRES; k++) begin
        buf_q[k] <= res[k];
      end
    end else if (pop) begin
      for (int k = 0; k < NRES - 1; k++) begin
        buf_q[k] <= buf_q[k + 1];
      end
    end
  end

endmodule

FILE: hdl/hdlczbs_checker.sv
// ----------------------------------------------------------------------------
// HDLC zero-bit stuffer checker
// Port-level checks on the result stream of the stuffer.
// ----------------------------------------------------------------------------
module hdlczbs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input hdlczbs_pkg::in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input hdlczbs_pkg::out_t out_data_o
);

  // A stalled input transaction holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input changed");

  // A stalled result transaction holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.valid_bits != 4'd0 && out_data_o.valid_bits <= 4'd8)
    else $error("valid_bits out of range");

  // Only the flushed tail of a message may be a partial byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.valid_bits != 4'd8 |-> out_data_o.last_out)
    else $error("partial byte not marked last");

  // Padding bits below the valid bit of a one-bit flushed byte are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.valid_bits == 4'd1 |-> out_data_o.out_byte[6:0] == 7'd0)
    else $error("padding not zero");

endmodule

bind hdlc_zero_bit_stuffer hdlczbs_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: sim/tb_hdlc_zero_bit_stuffer.sv
// ----------------------------------------------------------------------------
// HDLC zero-bit stuffer testbench
// Sends messages of payload bytes through the stuffer. A bit-level model of
// zero insertion and byte repacking predicts every output byte, and each
// output transaction is checked against it in order. The run goes through
// phases with no idling, with sender gaps, with receiver stalls, and with both.
// ----------------------------------------------------------------------------
module tb_hdlc_zero_bit_stuffer;

  localparam int unsigned RUN_LIMIT     = 5;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned PHASE_ITEMS   = 100;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid  = 1'b0;
  logic              in_stall;
  hdlczbs_pkg::in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  hdlczbs_pkg::out_t out_data;

  hdlczbs_pkg::in_t  payload_q[$];
  hdlczbs_pkg::out_t stuffed_q[$];

  // Predictor state: bits held between bytes of a message and the current
  // run of ones.
  logic [6:0]  held_bits  = '0;
  int unsigned held_count = 0;
  int unsigned ones_seen  = 0;
  logic [7:0]  pack_acc;
  int unsigned pack_cnt;
  int unsigned new_bytes;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        in_taken       = 1'b0;
  int unsigned mismatches     = 0;
  int unsigned cycles         = 0;

  hdlc_zero_bit_stuffer #(
    .ONES_LIMIT(RUN_LIMIT)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #2 clk = ~clk;

  function automatic void pack_bit(input logic b);
    hdlczbs_pkg::out_t r;
    pack_acc = {pack_acc[6:0], b};
    pack_cnt++;
    if (pack_cnt == 8) begin
      r.out_byte   = pack_acc;
      r.valid_bits = hdlczbs_pkg::VBITS_W'(8);
      r.last_out   = 1'b0;
      stuffed_q.push_back(r);
      new_bytes++;
      pack_acc = '0;
      pack_cnt = 0;
    end
  endfunction

  function automatic void stuff_byte(input hdlczbs_pkg::in_t item);
    hdlczbs_pkg::out_t r;
    logic b;
    pack_acc  = {1'b0, held_bits};
    pack_cnt  = held_count;
    new_bytes = 0;
    for (int j = hdlczbs_pkg::BYTE_W - 1; j >= 0; j--) begin
      b = item.data_byte[j];
      pack_bit(b);
      if (b) begin
        ones_seen++;
        if (ones_seen == RUN_LIMIT) begin
          pack_bit(1'b0);
          ones_seen = 0;
        end
      end else begin
        ones_seen = 0;
      end
    end
    if (item.end_of_message) begin
      if (pack_cnt > 0) begin
        r.out_byte   = pack_acc << (8 - pack_cnt);
        r.valid_bits = hdlczbs_pkg::VBITS_W'(pack_cnt);
        r.last_out   = 1'b1;
        stuffed_q.push_back(r);
      end else if (new_bytes > 0) begin
        stuffed_q[stuffed_q.size() - 1].last_out = 1'b1;
      end
      held_bits  = '0;
      held_count = 0;
      ones_seen  = 0;
    end else begin
      held_bits  = pack_acc[6:0];
      held_count = pack_cnt;
    end
  endfunction

  function automatic void add_byte(input logic [7:0] value, input logic eom);
    hdlczbs_pkg::in_t item;
    item.data_byte      = value;
    item.end_of_message = eom;
    payload_q.push_back(item);
  endfunction

  // Payload biased toward long runs of ones so that stuffing happens often.
  function automatic logic [7:0] pick_payload();
    logic [7:0] value;
    case ($urandom_range(3))
      0: value = 8'($urandom);
      1: value = 8'hFF;
      2: value = 8'($urandom) | 8'($urandom);
      default: value = ~(8'h01 << $urandom_range(7));
    endcase
    return value;
  endfunction

  function automatic int unsigned add_message(input int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      add_byte(pick_payload(), k == len - 1);
    end
    return len;
  endfunction

  // Driver: a new transaction is offered only once the previous one is taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (payload_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= payload_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: predicts on every accepted input and checks every accepted output.
  always @(posedge clk) begin
    hdlczbs_pkg::out_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        stuff_byte(in_data);
      end
      if (out_valid && !out_stall) begin
        if (stuffed_q.size() == 0) begin
          $display("%0t: unexpected output byte %h valid_bits %0d last %b", $time,
                   out_data.out_byte, out_data.valid_bits, out_data.last_out);
          mismatches++;
        end else begin
          want = stuffed_q.pop_front();
          if (out_data.out_byte !== want.out_byte ||
              out_data.valid_bits !== want.valid_bits ||
              out_data.last_out !== want.last_out) begin
            $display("%0t: expected byte %h bits %0d last %b, actual byte %h bits %0d last %b",
                     $time, want.out_byte, want.valid_bits, want.last_out,
                     out_data.out_byte, out_data.valid_bits, out_data.last_out);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned added;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Single-byte messages: zero byte on a boundary, all ones, the flag
    // pattern, and a stuffed zero spilling into a byte of its own.
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h7E, 1'b1);
    add_byte(8'h1F, 1'b1);
    // The stuffed zero completes the second output byte exactly.
    add_byte(8'h1F, 1'b0);
    add_byte(8'h7C, 1'b1);
    // A long run of ones across byte boundaries.
    for (int k = 0; k < 5; k++) begin
      add_byte(8'hFF, k == 4);
    end
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1);
    add_byte(8'h01, 1'b0);
    add_byte(8'h80, 1'b1);
    add_byte(8'h3E, 1'b0);
    add_byte(8'h00, 1'b1);
    add_byte(8'hFE, 1'b0);
    add_byte(8'h7F, 1'b1);
    add_byte(8'h55, 1'b0);
    add_byte(8'hAA, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      added = 0;
      while (added < PHASE_ITEMS) begin
        added += add_message($urandom_range(1, 8));
      end
      while (payload_q.size() > 0 || in_valid || stuffed_q.size() > 0) begin
        @(posedge clk);
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/hdlczbs_pkg.sv
hdl/hdlc_zero_bit_stuffer.sv
hdl/hdlczbs_checker.sv
sim/tb_hdlc_zero_bit_stuffer.sv
